@@ hw/rtl/dls_pkg.sv @@
`default_nettype none
package dls_pkg;

  localparam int MAX_PATTERNS = 63;
  localparam int CNT_W = $clog2(MAX_PATTERNS + 1);

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DASH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAP  = CFG_IDX_W'(1);

  localparam logic [30:0] DASH_RESET = 31'd65536;
  localparam logic [30:0] GAP_RESET  = 31'd32768;

  typedef logic signed [31:0] coord_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQMUL,
    S_SQRT,
    S_CCHK,
    S_CDIV,
    S_HMUL,
    S_HCALC,
    S_PSET,
    S_PMUL,
    S_PINIT,
    S_PDIV,
    S_PDONE,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/dls_cfg_if.sv @@
`default_nettype none
interface dls_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dls_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dls_line_if.sv @@
`default_nettype none
interface dls_line_if;
  logic            valid;
  logic            ready;
  dls_pkg::coord_t start_x;
  dls_pkg::coord_t start_y;
  dls_pkg::coord_t start_z;
  dls_pkg::coord_t end_x;
  dls_pkg::coord_t end_y;
  dls_pkg::coord_t end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dls_seg_if.sv @@
`default_nettype none
interface dls_seg_if;
  logic            valid;
  logic            ready;
  dls_pkg::coord_t seg_start_x;
  dls_pkg::coord_t seg_start_y;
  dls_pkg::coord_t seg_start_z;
  dls_pkg::coord_t seg_end_x;
  dls_pkg::coord_t seg_end_y;
  dls_pkg::coord_t seg_end_z;
  logic            last_segment;

  modport source (output valid, seg_start_x, seg_start_y, seg_start_z,
                  seg_end_x, seg_end_y, seg_end_z, last_segment, input ready);
  modport sink   (input valid, seg_start_x, seg_start_y, seg_start_z,
                  seg_end_x, seg_end_y, seg_end_z, last_segment, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dashed_line_segmenter.sv @@
// Steps: sum of squares on the shared multiplier, a 33-step square root, the pattern count,
//   the half dash, then a 35-step divide for each coordinate that is not trivial.
// One line at a time: a new line is taken only in idle, after its last segment beat;
//   each point's 35-step divide runs on the shared subtract unit.
// Each segment beat waits in the output register until taken.
// Reset (rst, synchronous, active high): back to idle, dash = 1.0, gap = 0.5.
`default_nettype none
module dashed_line_segmenter (
  input  logic       clk,
  input  logic       rst,
  dls_cfg_if.sink    cfg,
  dls_line_if.sink   line_in,
  dls_seg_if.source  seg_out
);

  localparam int CW = dls_pkg::CNT_W;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [33:0] mag36(input logic signed [35:0] v);
    logic signed [35:0] a;
    a = v[35] ? -v : v;
    return a[33:0];
  endfunction

  // ---------------------------------------------------------------- registers
  dls_pkg::state_t     state, state_next;
  logic [30:0]         dash, gap;
  dls_pkg::coord_t     sp [3];
  dls_pkg::coord_t     ep [3];
  logic signed [32:0]  dv [3];
  dls_pkg::coord_t     res [6];

  logic [5:0]          cnt;       // step counter of the sequencer
  logic [66:0]         acc;       // product accumulator / dividend shifter
  logic [34:0]         rem;       // partial remainder
  logic [34:0]         q;         // quotient / root shift-in
  logic [32:0]         len;       // line length, unsigned Q17.16
  logic [CW-1:0]       count, seg_idx, nlow;
  logic signed [35:0]  hdash, pos;
  logic [1:0]          axis;
  logic                endpt;     // working on segment end point
  logic [33:0]         ms;
  logic [32:0]         md;
  logic                neg;

  // shared multiplier, registered product
  logic [49:0]         prod;
  logic                prod_sh, prod_acc;

  // ---------------------------------------------------------------- datapath comb
  logic [31:0]         pat;
  logic [34:0]         numr;
  logic [32:0]         dd;
  logic                final_seg, last_coord, quick;
  logic signed [35:0]  seglen, s_cur;
  logic signed [32:0]  d_sel;
  dls_pkg::coord_t     start_sel;
  logic [2:0]          idx;
  logic [32:0]         mag_k;
  logic [32:0]         mul_a;
  logic [16:0]         mul_b;
  logic                mul_go, mul_sh, mul_acc;
  logic [36:0]         ua, ub, diff;
  logic                ge;
  logic [34:0]         qn;
  logic [CW-1:0]       qf;
  logic signed [39:0]  hv, hv_adj;
  logic signed [36:0]  offs;
  logic signed [37:0]  vsum;
  dls_pkg::coord_t     vsat;

  assign pat        = 32'(dash) + 32'(gap);
  assign numr       = {1'b0, len, 1'b0} + 35'(pat);
  assign dd         = {pat, 1'b0};
  assign final_seg  = (seg_idx == count);
  assign last_coord = endpt && (axis == 2'd2);
  assign seglen     = (seg_idx == '0) ? hdash : 36'(dash);
  assign s_cur      = endpt ? (pos + seglen) : pos;
  assign d_sel      = dv[axis];
  assign start_sel  = sp[axis];
  assign idx        = {1'b0, axis} + (endpt ? 3'd3 : 3'd0);
  assign quick      = (endpt && final_seg) || (s_cur == '0) || (d_sel == '0) || (len == '0);
  assign mag_k      = mag33(dv[cnt[2:1]]);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_go  = 1'b0;
    mul_sh  = 1'b0;
    mul_acc = 1'b0;
    case (state)
      dls_pkg::S_SQMUL: begin
        if (cnt < 6'd6) begin
          mul_go  = 1'b1;
          mul_acc = 1'b1;
          mul_sh  = cnt[0];
          mul_a   = mag_k;
          mul_b   = cnt[0] ? {1'b0, mag_k[32:17]} : mag_k[16:0];
        end
      end
      dls_pkg::S_PMUL: begin
        if (cnt < 6'd2) begin
          mul_go  = 1'b1;
          mul_acc = 1'b1;
          mul_sh  = cnt[0];
          mul_a   = md;
          mul_b   = cnt[0] ? ms[33:17] : ms[16:0];
        end
      end
      dls_pkg::S_HMUL: begin
        mul_go = 1'b1;
        mul_a  = {1'b0, pat};
        mul_b  = 17'(count);
      end
      default: ;
    endcase
  end

  // shared compare / subtract unit
  always_comb begin
    ua = '0;
    ub = '0;
    case (state)
      dls_pkg::S_SQRT: begin
        ua = {rem, acc[65:64]};
        ub = {2'b00, q[32:0], 2'b01};
      end
      dls_pkg::S_CCHK: begin
        ua = 37'(numr >> CW);
        ub = 37'(dd);
      end
      dls_pkg::S_CDIV: begin
        ua = 37'({rem[32:0], nlow[CW-1]});
        ub = 37'(dd);
      end
      dls_pkg::S_PDIV: begin
        ua = 37'({rem[32:0], acc[34]});
        ub = 37'(len);
      end
      default: ;
    endcase
  end

  assign diff   = ua - ub;
  assign ge     = (ua >= ub);
  assign qn     = {q[33:0], ge};
  assign qf     = qn[CW-1:0];
  assign hv     = 40'(dash) + 40'(len) - 40'(prod[37:0]);
  assign hv_adj = hv + 40'(hv[39]);           // truncate toward zero
  assign offs   = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
  assign vsum   = 38'(start_sel) + 38'(offs);

  always_comb begin
    if (vsum > 38'sd2147483647) begin
      vsat = 32'sh7fffffff;
    end else if (vsum < -38'sd2147483648) begin
      vsat = 32'sh80000000;
    end else begin
      vsat = vsum[31:0];
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign cfg.ready     = 1'b1;
  assign line_in.ready = (state == dls_pkg::S_IDLE);
  assign seg_out.valid = (state == dls_pkg::S_OUT);
  assign seg_out.seg_start_x  = res[0];
  assign seg_out.seg_start_y  = res[1];
  assign seg_out.seg_start_z  = res[2];
  assign seg_out.seg_end_x    = res[3];
  assign seg_out.seg_end_y    = res[4];
  assign seg_out.seg_end_z    = res[5];
  assign seg_out.last_segment = final_seg;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dls_pkg::S_IDLE:  if (line_in.valid) state_next = dls_pkg::S_SQMUL;
      dls_pkg::S_SQMUL: if (cnt == 6'd6) state_next = dls_pkg::S_SQRT;
      dls_pkg::S_SQRT:  if (cnt == 6'd0) state_next = dls_pkg::S_CCHK;
      dls_pkg::S_CCHK: begin
        if (pat == '0) state_next = dls_pkg::S_PSET;
        else if (ge)   state_next = dls_pkg::S_HMUL;
        else           state_next = dls_pkg::S_CDIV;
      end
      dls_pkg::S_CDIV: begin
        if (cnt == 6'd0) state_next = (qf == '0) ? dls_pkg::S_PSET : dls_pkg::S_HMUL;
      end
      dls_pkg::S_HMUL:  state_next = dls_pkg::S_HCALC;
      dls_pkg::S_HCALC: state_next = dls_pkg::S_PSET;
      dls_pkg::S_PSET: begin
        if (!quick)          state_next = dls_pkg::S_PMUL;
        else if (last_coord) state_next = dls_pkg::S_OUT;
      end
      dls_pkg::S_PMUL:  if (cnt == 6'd2) state_next = dls_pkg::S_PINIT;
      dls_pkg::S_PINIT: state_next = dls_pkg::S_PDIV;
      dls_pkg::S_PDIV:  if (cnt == 6'd0) state_next = dls_pkg::S_PDONE;
      dls_pkg::S_PDONE: state_next = last_coord ? dls_pkg::S_OUT : dls_pkg::S_PSET;
      dls_pkg::S_OUT: begin
        if (seg_out.ready) state_next = final_seg ? dls_pkg::S_IDLE : dls_pkg::S_PSET;
      end
      default: state_next = dls_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- config regs
  always_ff @(posedge clk) begin
    if (rst) begin
      dash <= dls_pkg::DASH_RESET;
      gap  <= dls_pkg::GAP_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == dls_pkg::REG_DASH) dash <= cfg.data[30:0];
      if (cfg.index == dls_pkg::REG_GAP)  gap  <= cfg.data[30:0];
    end
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_acc <= 1'b0;
    end else begin
      prod_acc <= mul_go && mul_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      prod    <= 50'(mul_a) * 50'(mul_b);
      prod_sh <= mul_sh;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (prod_acc) begin
      acc <= acc + (prod_sh ? (67'(prod) << 17) : 67'(prod));
    end
    case (state)
      dls_pkg::S_IDLE: begin
        sp[0] <= line_in.start_x;
        sp[1] <= line_in.start_y;
        sp[2] <= line_in.start_z;
        ep[0] <= line_in.end_x;
        ep[1] <= line_in.end_y;
        ep[2] <= line_in.end_z;
        dv[0] <= 33'(line_in.end_x) - 33'(line_in.start_x);
        dv[1] <= 33'(line_in.end_y) - 33'(line_in.start_y);
        dv[2] <= 33'(line_in.end_z) - 33'(line_in.start_z);
        acc   <= '0;
        cnt   <= '0;
        rem   <= '0;
        q     <= '0;
      end
      dls_pkg::S_SQMUL: begin
        cnt <= (cnt == 6'd6) ? 6'd32 : cnt + 6'd1;
      end
      dls_pkg::S_SQRT: begin
        acc <= acc << 2;
        rem <= ge ? diff[34:0] : ua[34:0];
        q   <= qn;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) len <= {q[31:0], ge};
      end
      dls_pkg::S_CCHK: begin
        q       <= '0;
        rem     <= 35'(numr >> CW);
        nlow    <= numr[CW-1:0];
        cnt     <= 6'(CW - 1);
        seg_idx <= '0;
        pos     <= '0;
        axis    <= 2'd0;
        endpt   <= 1'b0;
        if (pat == '0) count <= '0;
        else if (ge)   count <= CW'(dls_pkg::MAX_PATTERNS);
      end
      dls_pkg::S_CDIV: begin
        rem  <= ge ? diff[34:0] : ua[34:0];
        nlow <= nlow << 1;
        q    <= qn;
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          count <= (32'(qf) > 32'(dls_pkg::MAX_PATTERNS)) ?
                   CW'(dls_pkg::MAX_PATTERNS) : qf;
        end
      end
      dls_pkg::S_HCALC: begin
        hdash <= hv_adj[36:1];
      end
      dls_pkg::S_PSET: begin
        if (quick) begin
          res[idx] <= (endpt && final_seg) ? ep[axis] : start_sel;
          if (axis == 2'd2) begin
            axis  <= 2'd0;
            endpt <= 1'b1;
          end else begin
            axis <= axis + 2'd1;
          end
        end else begin
          ms  <= mag36(s_cur);
          md  <= mag33(d_sel);
          neg <= d_sel[32] ^ s_cur[35];
          acc <= 67'(len >> 1);            // rounding half
          cnt <= '0;
        end
      end
      dls_pkg::S_PMUL: begin
        cnt <= cnt + 6'd1;
      end
      dls_pkg::S_PINIT: begin
        rem <= 35'(acc[66:35]);
        q   <= '0;
        cnt <= 6'd34;
      end
      dls_pkg::S_PDIV: begin
        acc <= acc << 1;
        rem <= ge ? diff[34:0] : ua[34:0];
        q   <= qn;
        cnt <= cnt - 6'd1;
      end
      dls_pkg::S_PDONE: begin
        res[idx] <= vsat;
        if (axis == 2'd2) begin
          axis  <= 2'd0;
          endpt <= 1'b1;
        end else begin
          axis <= axis + 2'd1;
        end
      end
      dls_pkg::S_OUT: begin
        if (seg_out.ready) begin
          pos     <= pos + seglen + 36'(gap);
          seg_idx <= seg_idx + CW'(1);
          axis    <= 2'd0;
          endpt   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    line_in.ready |-> !seg_out.valid)
    else $error("input taken while a segment beat is pending");

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    seg_out.valid |-> (seg_idx <= count &&
                       32'(count) <= 32'(dls_pkg::MAX_PATTERNS)))
    else $error("segment index past pattern count");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (seg_out.valid && seg_out.last_segment) |->
      (res[3] == ep[0] && res[4] == ep[1] && res[5] == ep[2]))
    else $error("last segment does not end at end point");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (line_in.valid && line_in.ready) |=> !line_in.ready)
    else $error("ready right after a line beat");

endmodule
`default_nettype wire
